// File: rtl/bbi_pkg.sv
// Shared types, widths, register codes and fixed-point helpers for the
// box bounce integrator. No dependencies; every other rtl file imports it.
package bbi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Item field widths
  localparam int FIX_W     = 32;
  localparam int BOX_W     = 10;
  localparam int DT_W      = 12;

  // Register widths
  localparam int GRAV_W    = 24;
  localparam int FLOOR_W   = 26;
  localparam int BOUNCE_W  = 17;
  localparam int DRAG_W    = 24;
  localparam int ARENA_W   = 26;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register stages: kinematics first, then contact handling
  localparam int PIPE_STAGES = 8;
  localparam int KIN_STAGES  = 4;

  // Register reset values (Q16.16 encodings)
  localparam logic [GRAV_W-1:0]   GRAVITY_RST = GRAV_W'(642908);
  localparam logic [FLOOR_W-1:0]  FLOOR_RST   = FLOOR_W'(36044800);
  localparam logic [BOUNCE_W-1:0] BOUNCE_RST  = BOUNCE_W'(39322);
  localparam logic [DRAG_W-1:0]   DRAG_RST    = DRAG_W'(131072);
  localparam logic [ARENA_W-1:0]  ARENA_RST   = ARENA_W'(65536000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY_ACCEL = 3'd0,
    CFG_FLOOR_LEVEL   = 3'd1,
    CFG_BOUNCE_KEEP   = 3'd2,
    CFG_FLOOR_DRAG    = 3'd3,
    CFG_ARENA_WIDTH   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [GRAV_W-1:0]   gravity_accel;
    logic [FLOOR_W-1:0]  floor_level;
    logic [BOUNCE_W-1:0] bounce_keep;
    logic [DRAG_W-1:0]   floor_drag;
    logic [ARENA_W-1:0]  arena_width;
  } cfg_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] pos_x;
    logic signed [FIX_W-1:0] pos_y;
    logic signed [FIX_W-1:0] vel_x;
    logic signed [FIX_W-1:0] vel_y;
    logic [BOX_W-1:0]        box_width;
    logic [BOX_W-1:0]        box_height;
    logic [DT_W-1:0]         time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] new_pos_x;
    logic signed [FIX_W-1:0] new_pos_y;
    logic signed [FIX_W-1:0] new_vel_x;
    logic signed [FIX_W-1:0] new_vel_y;
    logic                    on_floor;
  } out_item_t;

  // Stage enables and valid bits from the pipeline controller
  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;
    logic [PIPE_STAGES-1:0] vld;
  } pipe_ctl_t;

  // Kinematics result handed to the contact stages
  typedef struct packed {
    logic signed [FIX_W-1:0] pos_x;      // after both walls
    logic signed [FIX_W-1:0] pos_y;      // free flight
    logic signed [FIX_W-1:0] floor_thr;  // floor minus half height, saturated
    logic signed [FIX_W-1:0] vel_x;
    logic signed [FIX_W-1:0] vel_x_kept; // vel_x with floor friction
    logic signed [FIX_W-1:0] vel_y;
    logic signed [FIX_W-1:0] vel_y_bounce;
    logic                    vel_y_big;  // |vel_y| above the rest threshold
    logic                    hit_left;
    logic                    hit_right;
  } kin_t;

  function automatic logic [FIX_W-1:0] abs32(input logic signed [FIX_W-1:0] v);
    return v[FIX_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic [63:0] mag, input logic neg);
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/bbi_if.sv
// Valid/ready channel interfaces: box input, box result, register writes.
// Depends on bbi_pkg for field widths.
interface bbi_in_if import bbi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [FIX_W-1:0] pos_x;
  logic signed [FIX_W-1:0] pos_y;
  logic signed [FIX_W-1:0] vel_x;
  logic signed [FIX_W-1:0] vel_y;
  logic [BOX_W-1:0]        box_width;
  logic [BOX_W-1:0]        box_height;
  logic [DT_W-1:0]         time_step;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, box_width, box_height,
                  time_step, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, box_width, box_height,
                  time_step, output ready);
endinterface

interface bbi_out_if import bbi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [FIX_W-1:0] new_pos_x;
  logic signed [FIX_W-1:0] new_pos_y;
  logic signed [FIX_W-1:0] new_vel_x;
  logic signed [FIX_W-1:0] new_vel_y;
  logic                    on_floor;

  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, on_floor,
                  input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, on_floor,
                  output ready);
endinterface

interface bbi_cfg_if import bbi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/bbi_cfg_regs.sv
// Configuration register file for the box bounce integrator.
// Depends on bbi_pkg and bbi_cfg_if.
module bbi_cfg_regs import bbi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbi_cfg_if.sink       cfg_i,
  output cfg_t          cfg_o
);

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.gravity_accel <= GRAVITY_RST;
      regs_q.floor_level   <= FLOOR_RST;
      regs_q.bounce_keep   <= BOUNCE_RST;
      regs_q.floor_drag    <= DRAG_RST;
      regs_q.arena_width   <= ARENA_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        CFG_GRAVITY_ACCEL: regs_q.gravity_accel <= cfg_i.wdata[GRAV_W-1:0];
        CFG_FLOOR_LEVEL:   regs_q.floor_level   <= cfg_i.wdata[FLOOR_W-1:0];
        CFG_BOUNCE_KEEP:   regs_q.bounce_keep   <= cfg_i.wdata[BOUNCE_W-1:0];
        CFG_FLOOR_DRAG:    regs_q.floor_drag    <= cfg_i.wdata[DRAG_W-1:0];
        CFG_ARENA_WIDTH:   regs_q.arena_width   <= cfg_i.wdata[ARENA_W-1:0];
        default: ;  // unused index: dropped
      endcase
    end
  end

endmodule

// File: rtl/bbi_pipe_ctrl.sv
// Valid bits and per-stage load enables; stalled stages hold, bubbles close up.
// Depends on bbi_pkg.
module bbi_pipe_ctrl import bbi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [PIPE_STAGES-1:0] vld_q, vld_d, en;

  always_comb begin
    en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_ready_i;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en  = en;
  assign ctl_o.vld = vld_q;

endmodule

// File: rtl/bbi_kinematics.sv
// Stages 1-4: gravity, Euler position advance, floor/wall candidates.
// Depends on bbi_pkg.
module bbi_kinematics import bbi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  output kin_t      kin_o
);

  localparam int GDT_W  = GRAV_W + DT_W;
  localparam int VDT_W  = FIX_W + DT_W;
  localparam int DDT_W  = DRAG_W + DT_W;
  localparam int KEEP_W = FRAC_BITS + 1;
  localparam int VXK_W  = FIX_W + KEEP_W;
  localparam int VYB_W  = FIX_W + BOUNCE_W;
  localparam int HALF_W = BOX_W + FRAC_BITS - 1;
  localparam int CMP_W  = ((HALF_W > 30) ? HALF_W : 30) + 3;
  localparam logic [KEEP_W-1:0] ONE_K = KEEP_W'(1) << FRAC_BITS;
  localparam logic [DDT_W-1:0]  ONE_D = DDT_W'(1) << FRAC_BITS;
  localparam logic [FIX_W-1:0]  TENTH = FIX_W'(((1 << FRAC_BITS) + 5) / 10);

  // ---- stage 1: products with dt
  logic signed [FIX_W-1:0] s1_x_q, s1_y_q, s1_vx_q, s1_vy_q;
  logic [BOX_W-1:0]        s1_w_q, s1_h_q;
  logic [DT_W-1:0]         s1_dt_q;
  logic [GDT_W-1:0]        s1_gdt_q, s1_gdt_d;
  logic [VDT_W-1:0]        s1_vxdt_q, s1_vxdt_d;
  logic [DDT_W-1:0]        s1_ddt_q, s1_ddt_d;

  always_comb begin
    s1_gdt_d  = GDT_W'(cfg_i.gravity_accel) * GDT_W'(item_i.time_step);
    s1_vxdt_d = VDT_W'(abs32(item_i.vel_x)) * VDT_W'(item_i.time_step);
    s1_ddt_d  = DDT_W'(cfg_i.floor_drag) * DDT_W'(item_i.time_step);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      s1_x_q    <= item_i.pos_x;
      s1_y_q    <= item_i.pos_y;
      s1_vx_q   <= item_i.vel_x;
      s1_vy_q   <= item_i.vel_y;
      s1_w_q    <= item_i.box_width;
      s1_h_q    <= item_i.box_height;
      s1_dt_q   <= item_i.time_step;
      s1_gdt_q  <= s1_gdt_d;
      s1_vxdt_q <= s1_vxdt_d;
      s1_ddt_q  <= s1_ddt_d;
    end
  end

  // ---- stage 2: vy and x updates, friction keep factor, floor threshold
  logic signed [FIX_W-1:0] s2_x_q, s2_x_d, s2_vy_q, s2_vy_d, s2_thr_q, s2_thr_d;
  logic signed [FIX_W-1:0] s2_y_q, s2_vx_q;
  logic [DT_W-1:0]         s2_dt_q;
  logic [KEEP_W-1:0]       s2_keep_q, s2_keep_d;
  logic [HALF_W-1:0]       s2_halfw_q, s2_halfw_d;
  logic [HALF_W-1:0]       half_h;
  logic [DDT_W-1:0]        drag_sh;
  logic signed [CMP_W-1:0] thr_w;

  always_comb begin
    s2_vy_d    = sat32(64'(s1_vy_q) + signed'(64'(s1_gdt_q >> FRAC_BITS)));
    s2_x_d     = sat32(64'(s1_x_q) +
                       apply_sign(64'(s1_vxdt_q >> FRAC_BITS), s1_vx_q[FIX_W-1]));
    drag_sh    = s1_ddt_q >> FRAC_BITS;
    s2_keep_d  = (drag_sh >= ONE_D) ? '0 : (ONE_K - KEEP_W'(drag_sh));
    half_h     = HALF_W'(s1_h_q) << (FRAC_BITS - 1);
    s2_halfw_d = HALF_W'(s1_w_q) << (FRAC_BITS - 1);
    thr_w      = CMP_W'(cfg_i.floor_level) - CMP_W'(half_h);
    s2_thr_d   = sat32(64'(thr_w));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      s2_x_q     <= s2_x_d;
      s2_y_q     <= s1_y_q;
      s2_vx_q    <= s1_vx_q;
      s2_vy_q    <= s2_vy_d;
      s2_dt_q    <= s1_dt_q;
      s2_keep_q  <= s2_keep_d;
      s2_halfw_q <= s2_halfw_d;
      s2_thr_q   <= s2_thr_d;
    end
  end

  // ---- stage 3: vy*dt, friction and bounce products, left wall
  logic [VDT_W-1:0]        s3_vydt_q, s3_vydt_d;
  logic [VXK_W-1:0]        s3_vxk_q, s3_vxk_d;
  logic [VYB_W-1:0]        s3_vyb_q, s3_vyb_d;
  logic signed [FIX_W-1:0] s3_xl_q, s3_xl_d, s3_y_q, s3_vx_q, s3_vy_q, s3_thr_q;
  logic signed [CMP_W-1:0] s3_rlim_q, s3_rlim_d;
  logic                    s3_left_q, s3_left_d, s3_big_q, s3_big_d;
  logic signed [CMP_W-1:0] halfw_s, x2_s;

  always_comb begin
    s3_vydt_d = VDT_W'(abs32(s2_vy_q)) * VDT_W'(s2_dt_q);
    s3_vxk_d  = VXK_W'(abs32(s2_vx_q)) * VXK_W'(s2_keep_q);
    s3_vyb_d  = VYB_W'(abs32(s2_vy_q)) * VYB_W'(cfg_i.bounce_keep);
    s3_big_d  = abs32(s2_vy_q) > TENTH;
    halfw_s   = CMP_W'(s2_halfw_q);
    x2_s      = CMP_W'(s2_x_q);
    s3_left_d = x2_s < halfw_s;
    s3_xl_d   = s3_left_d ? sat32(64'(halfw_s)) : s2_x_q;
    s3_rlim_d = CMP_W'(cfg_i.arena_width) - halfw_s;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      s3_vydt_q <= s3_vydt_d;
      s3_vxk_q  <= s3_vxk_d;
      s3_vyb_q  <= s3_vyb_d;
      s3_big_q  <= s3_big_d;
      s3_left_q <= s3_left_d;
      s3_xl_q   <= s3_xl_d;
      s3_rlim_q <= s3_rlim_d;
      s3_y_q    <= s2_y_q;
      s3_vx_q   <= s2_vx_q;
      s3_vy_q   <= s2_vy_q;
      s3_thr_q  <= s2_thr_q;
    end
  end

  // ---- stage 4: y update, signed candidates, right wall
  kin_t s4_q, s4_d;

  always_comb begin
    s4_d.pos_y        = sat32(64'(s3_y_q) +
                              apply_sign(64'(s3_vydt_q >> FRAC_BITS), s3_vy_q[FIX_W-1]));
    s4_d.vel_x_kept   = sat32(apply_sign(64'(s3_vxk_q >> FRAC_BITS), s3_vx_q[FIX_W-1]));
    s4_d.vel_y_bounce = sat32(apply_sign(64'(s3_vyb_q >> FRAC_BITS), !s3_vy_q[FIX_W-1]));
    s4_d.hit_right    = CMP_W'(s3_xl_q) > s3_rlim_q;
    s4_d.pos_x        = s4_d.hit_right ? sat32(64'(s3_rlim_q)) : s3_xl_q;
    s4_d.floor_thr    = s3_thr_q;
    s4_d.vel_x        = s3_vx_q;
    s4_d.vel_y        = s3_vy_q;
    s4_d.vel_y_big    = s3_big_q;
    s4_d.hit_left     = s3_left_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[KIN_STAGES-1]) begin
      s4_q <= s4_d;
    end
  end

  assign kin_o = s4_q;

endmodule

// File: rtl/bbi_contact.sv
// Stages 5-8: floor contact select, then left and right wall velocity scaling.
// Depends on bbi_pkg.
module bbi_contact import bbi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  kin_t      kin_i,
  output out_item_t item_o
);

  localparam int FF_W   = FRAC_BITS;
  localparam int PROD_W = FIX_W + FF_W;
  localparam logic [FF_W-1:0] FOUR_FIFTHS = FF_W'(((1 << FRAC_BITS) * 4 + 2) / 5);

  // ---- stage 5: floor
  logic signed [FIX_W-1:0] c1_x_q, c1_y_q, c1_y_d, c1_vx_q, c1_vx_d, c1_vy_q, c1_vy_d;
  logic                    c1_floor_q, c1_floor_d, c1_left_q, c1_right_q;

  always_comb begin
    c1_floor_d = kin_i.pos_y >= kin_i.floor_thr;
    c1_y_d     = c1_floor_d ? kin_i.floor_thr : kin_i.pos_y;
    c1_vx_d    = c1_floor_d ? kin_i.vel_x_kept : kin_i.vel_x;
    if (!c1_floor_d) begin
      c1_vy_d = kin_i.vel_y;
    end else if (kin_i.vel_y_big) begin
      c1_vy_d = kin_i.vel_y_bounce;
    end else begin
      c1_vy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[KIN_STAGES]) begin
      c1_x_q     <= kin_i.pos_x;
      c1_y_q     <= c1_y_d;
      c1_vx_q    <= c1_vx_d;
      c1_vy_q    <= c1_vy_d;
      c1_floor_q <= c1_floor_d;
      c1_left_q  <= kin_i.hit_left;
      c1_right_q <= kin_i.hit_right;
    end
  end

  // ---- stage 6: |vx| * 0.8 for the left wall
  logic [PROD_W-1:0]       c2_a_q, c2_a_d;
  logic signed [FIX_W-1:0] c2_x_q, c2_y_q, c2_vx_q, c2_vy_q;
  logic                    c2_floor_q, c2_left_q, c2_right_q;

  assign c2_a_d = PROD_W'(abs32(c1_vx_q)) * PROD_W'(FOUR_FIFTHS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[KIN_STAGES+1]) begin
      c2_a_q     <= c2_a_d;
      c2_x_q     <= c1_x_q;
      c2_y_q     <= c1_y_q;
      c2_vx_q    <= c1_vx_q;
      c2_vy_q    <= c1_vy_q;
      c2_floor_q <= c1_floor_q;
      c2_left_q  <= c1_left_q;
      c2_right_q <= c1_right_q;
    end
  end

  // ---- stage 7: apply left wall, |vx| * 0.8 for the right wall
  logic [PROD_W-1:0]       c3_b_q, c3_b_d;
  logic signed [FIX_W-1:0] c3_vxl_q, c3_vxl_d, c3_x_q, c3_y_q, c3_vy_q;
  logic                    c3_floor_q, c3_right_q;

  always_comb begin
    c3_vxl_d = c2_left_q ? signed'(FIX_W'(c2_a_q >> FRAC_BITS)) : c2_vx_q;
    c3_b_d   = PROD_W'(abs32(c3_vxl_d)) * PROD_W'(FOUR_FIFTHS);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[KIN_STAGES+2]) begin
      c3_b_q     <= c3_b_d;
      c3_vxl_q   <= c3_vxl_d;
      c3_x_q     <= c2_x_q;
      c3_y_q     <= c2_y_q;
      c3_vy_q    <= c2_vy_q;
      c3_floor_q <= c2_floor_q;
      c3_right_q <= c2_right_q;
    end
  end

  // ---- stage 8: apply right wall, output register
  out_item_t c4_q, c4_d;

  always_comb begin
    c4_d.new_pos_x = c3_x_q;
    c4_d.new_pos_y = c3_y_q;
    c4_d.new_vel_x = c3_right_q ? -signed'(FIX_W'(c3_b_q >> FRAC_BITS)) : c3_vxl_q;
    c4_d.new_vel_y = c3_vy_q;
    c4_d.on_floor  = c3_floor_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[PIPE_STAGES-1]) begin
      c4_q <= c4_d;
    end
  end

  assign item_o = c4_q;

endmodule

// File: rtl/box_bounce_integrator.sv
// Top level of the box bounce integrator: config registers, pipeline control,
// kinematics and contact stages. Depends on bbi_pkg, bbi_if and the bbi_* modules.
//
//  channel | modport | transfer when         | payload
//  --------+---------+-----------------------+------------------------------------------
//  in_i    | sink    | valid & ready         | pos_x pos_y vel_x vel_y box_width
//          |         |                       | box_height time_step
//  out_o   | source  | valid & ready         | new_pos_x new_pos_y new_vel_x new_vel_y
//          |         |                       | on_floor
//  cfg_i   | sink    | valid (ready tied 1)  | reg_index wdata
//
// Eight register stages; one box per cycle sustained while out_o.ready stays high.
// The depth is set by the multiplier chain: vx*dt, vy*dt after the gravity add,
// then two dependent 0.8 scalings at the walls.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// output holds in place while bubbles ahead of it fill; ready depends on out_o.ready.
// Reset clears all valid bits and restores the register defaults; data stages
// carry no reset.
module box_bounce_integrator import bbi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bbi_in_if.sink   in_i,
  bbi_out_if.source out_o,
  bbi_cfg_if.sink  cfg_i
);

  cfg_t      cfg;
  pipe_ctl_t ctl;
  in_item_t  in_item;
  kin_t      kin;
  out_item_t out_item;

  // Register file; the user must write it only while the pipeline is drained (not enforced here)
  bbi_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Valid bits and stage enables
  bbi_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  assign in_i.ready = ctl.en[0];

  always_comb begin
    in_item.pos_x      = in_i.pos_x;
    in_item.pos_y      = in_i.pos_y;
    in_item.vel_x      = in_i.vel_x;
    in_item.vel_y      = in_i.vel_y;
    in_item.box_width  = in_i.box_width;
    in_item.box_height = in_i.box_height;
    in_item.time_step  = in_i.time_step;
  end

  // Stages 1-4: gravity, Euler advance, speculative floor and wall terms
  bbi_kinematics #(
    .FRAC_BITS (FRAC_BITS)
  ) u_kinematics (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .cfg_i  (cfg),
    .item_i (in_item),
    .kin_o  (kin)
  );

  // Stages 5-8: floor contact select, wall velocity scaling, output register
  bbi_contact #(
    .FRAC_BITS (FRAC_BITS)
  ) u_contact (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .kin_i  (kin),
    .item_o (out_item)
  );

  assign out_o.valid     = ctl.vld[PIPE_STAGES-1];
  assign out_o.new_pos_x = out_item.new_pos_x;
  assign out_o.new_pos_y = out_item.new_pos_y;
  assign out_o.new_vel_x = out_item.new_vel_x;
  assign out_o.new_vel_y = out_item.new_vel_y;
  assign out_o.on_floor  = out_item.on_floor;

`ifndef SYNTHESIS
  // Empty output slot means every stage can load, so input must be open
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input not ready although output stage is free");

  // An accepted box must occupy the first stage next cycle
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> ctl.vld[0])
    else $error("accepted box missing from first stage");

  // A valid stage that was not enabled keeps its box
  a_stall_keeps_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((ctl.vld & $past(ctl.vld & ~ctl.en)) == $past(ctl.vld & ~ctl.en)))
    else $error("stalled stage dropped its box");
`endif

endmodule
